>>> rtl/io_status_frame_receiver_core_defines.svh
// Assertion helpers used by the receiver frame checker.
// Both expect aclk and aresetn in scope.
`ifndef IO_STATUS_FRAME_RECEIVER_CORE_DEFINES_SVH
`define IO_STATUS_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication
`define ISFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ISFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/isfr_pkg.sv
package isfr_pkg;

    // One received word as held in the input register
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } word_t;

    typedef enum logic [2:0] {
        ST_OK_SAME    = 3'd0,
        ST_OK_CHANGED = 3'd1,
        ST_BAD_LENGTH = 3'd2,
        ST_BAD_HEADER = 3'd3,
        ST_BAD_CRC    = 3'd4
    } status_t;

    localparam logic [3:0]  FRAME_LEN     = 4'd7;
    localparam logic [3:0]  POS_SAT       = 4'd8;
    localparam logic [3:0]  CRC_END_POS   = 4'd5;
    localparam logic [7:0]  FUNC_CODE     = 8'h01;
    localparam logic [7:0]  BYTE_COUNT    = 8'h02;
    localparam logic [7:0]  ADDR_RESET    = 8'h63;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    // CRC-16/MODBUS update by one byte, reflected form
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/isfr_in_stage.sv
module isfr_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
    input  logic                s_axis_tlast,
    output logic                word_valid,
    output isfr_pkg::word_t     word,
    input  logic                word_take
);

    logic            in_valid_reg;
    logic            in_valid_next;
    isfr_pkg::word_t in_word_reg;
    logic            load;

    // Take a new word when the register is empty or drains this cycle
    assign s_axis_tready = !in_valid_reg || word_take;
    assign load          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (load) begin
            in_valid_next = 1'b1;
        end else if (word_take) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture payload
    always_ff @(posedge aclk) begin
        if (load) begin
            in_word_reg.rx_byte   <= s_axis_tdata;
            in_word_reg.frame_end <= s_axis_tlast;
        end
    end

    assign word_valid = in_valid_reg;
    assign word       = in_word_reg;

endmodule

>>> rtl/isfr_frame_check.sv
`include "io_status_frame_receiver_core_defines.svh"

module isfr_frame_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          device_address,
    input  logic                word_valid,
    input  isfr_pkg::word_t     word,
    output logic                word_take,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata    // [2:0] status, [10:3] input_bits
);

    // Per-frame state
    logic [3:0]  pos_reg,      pos_next,      pos_step;
    logic [15:0] crc_reg,      crc_next,      crc_step;
    logic        hdr_good_reg, hdr_good_next, hdr_step;
    logic [7:0]  cap_reg,      cap_next,      cap_step;
    logic [7:0]  crc_lo_reg,   crc_lo_next,   lo_step;
    logic [7:0]  crc_hi_reg,   crc_hi_next,   hi_step;
    logic [7:0]  last_in_reg,  last_in_next;

    // Result register
    logic              m_valid_reg, m_valid_next;
    isfr_pkg::status_t m_status_reg, status_next;
    logic [7:0]        m_bits_reg;

    logic out_ready;
    logic result_load;

    assign out_ready   = !m_valid_reg || m_axis_tready;
    assign word_take   = word_valid && (!word.frame_end || out_ready);
    assign result_load = word_take && word.frame_end;

    // Fold the current word into the frame state
    always_comb begin
        hdr_step = hdr_good_reg;
        cap_step = cap_reg;
        lo_step  = crc_lo_reg;
        hi_step  = crc_hi_reg;
        unique case (pos_reg)
            4'd0: if (word.rx_byte != device_address) hdr_step = 1'b0;
            4'd1: if (word.rx_byte != isfr_pkg::FUNC_CODE) hdr_step = 1'b0;
            4'd2: if (word.rx_byte != isfr_pkg::BYTE_COUNT) hdr_step = 1'b0;
            4'd3: cap_step = word.rx_byte;
            4'd5: lo_step = word.rx_byte;
            4'd6: hi_step = word.rx_byte;
            default: ;
        endcase
        crc_step = (pos_reg < isfr_pkg::CRC_END_POS) ?
                   isfr_pkg::crc16_byte(crc_reg, word.rx_byte) : crc_reg;
        pos_step = (pos_reg < isfr_pkg::POS_SAT) ? 4'(pos_reg + 4'd1) : pos_reg;
    end

    // Classify the frame at its last word
    always_comb begin
        last_in_next = last_in_reg;
        priority if (pos_step != isfr_pkg::FRAME_LEN) begin
            status_next = isfr_pkg::ST_BAD_LENGTH;
        end else if (!hdr_step) begin
            status_next = isfr_pkg::ST_BAD_HEADER;
        end else if (crc_step != {hi_step, lo_step}) begin
            status_next = isfr_pkg::ST_BAD_CRC;
        end else if (cap_step != last_in_reg) begin
            status_next  = isfr_pkg::ST_OK_CHANGED;
            last_in_next = cap_step;
        end else begin
            status_next = isfr_pkg::ST_OK_SAME;
        end
    end

    // Advance or clear the frame state
    always_comb begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        hdr_good_next = hdr_good_reg;
        cap_next      = cap_reg;
        crc_lo_next   = crc_lo_reg;
        crc_hi_next   = crc_hi_reg;
        if (result_load) begin
            pos_next      = '0;
            crc_next      = isfr_pkg::CRC_INIT;
            hdr_good_next = 1'b1;
            cap_next      = '0;
            crc_lo_next   = '0;
            crc_hi_next   = '0;
        end else if (word_take) begin
            pos_next      = pos_step;
            crc_next      = crc_step;
            hdr_good_next = hdr_step;
            cap_next      = cap_step;
            crc_lo_next   = lo_step;
            crc_hi_next   = hi_step;
        end
    end

    always_comb begin
        if (result_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            crc_reg      <= isfr_pkg::CRC_INIT;
            hdr_good_reg <= 1'b1;
            cap_reg      <= '0;
            crc_lo_reg   <= '0;
            crc_hi_reg   <= '0;
            last_in_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            hdr_good_reg <= hdr_good_next;
            cap_reg      <= cap_next;
            crc_lo_reg   <= crc_lo_next;
            crc_hi_reg   <= crc_hi_next;
            last_in_reg  <= result_load ? last_in_next : last_in_reg;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Load result payload
    always_ff @(posedge aclk) begin
        if (result_load) begin
            m_status_reg <= status_next;
            m_bits_reg   <= last_in_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b00000, m_bits_reg, m_status_reg};

    `ISFR_ASSERT_NOW(a_pos_saturates, 1'b1, pos_reg <= isfr_pkg::POS_SAT,
        "byte position ran past saturation")
    `ISFR_ASSERT_NEXT(a_clear_after_result, result_load,
        pos_reg == 4'd0 && crc_reg == isfr_pkg::CRC_INIT && hdr_good_reg,
        "frame state not cleared after result")
    `ISFR_ASSERT_NEXT(a_changed_updates_last,
        result_load && status_next == isfr_pkg::ST_OK_CHANGED,
        last_in_reg != $past(last_in_reg) && m_bits_reg == last_in_reg,
        "changed status without new input byte")

endmodule

>>> rtl/io_status_frame_receiver_core.sv
// Status frame receiver: checks 7-byte read-coils style responses.
// Input channel s_axis: one received byte per word in tdata[7:0]; tlast
//   marks the last byte of a received chunk.
// Result channel m_axis: one word per chunk end; tdata[2:0] status
//   (0 ok same, 1 ok changed, 2 wrong length, 3 header mismatch,
//   4 CRC mismatch), tdata[10:3] last accepted input byte.
// cfg_wr_en / cfg_wr_data write the expected device address (reset 0x63);
//   write it only while no chunk is in progress.
// A result reaches m_axis through the input register, then the result
//   register, after the last byte of the chunk is accepted.
// Throughput: one byte per cycle while no chunk end waits on m_axis;
//   a byte-wide CRC update sits between input and frame state registers.
// Reset clears the chunk state, the remembered input byte (to 0) and both
//   valid flags, and returns the address register to 0x63.
// When m_axis stalls, bytes that do not end a chunk keep flowing; a chunk
//   end waits in the input register until the result register frees.
module io_status_frame_receiver_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [2:0] status, [10:3] input_bits
);

    logic [7:0]      dev_addr_reg;
    logic            word_valid;
    logic            word_take;
    isfr_pkg::word_t word;

    // Hold the expected device address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= isfr_pkg::ADDR_RESET;
        end else if (cfg_wr_en) begin
            dev_addr_reg <= cfg_wr_data;
        end
    end

    isfr_in_stage u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .word_valid    (word_valid),
        .word          (word),
        .word_take     (word_take)
    );

    isfr_frame_check u_frame_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .device_address (dev_addr_reg),
        .word_valid     (word_valid),
        .word           (word),
        .word_take      (word_take),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

endmodule
